// File: hdl/tctw_pkg.sv
// ----------------------------------------------------------------------------
// tctw_pkg: shared types and constants for the text-cell terminal writer
// Screen geometry, character codes, and the command/status bundles passed
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tctw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int IDX_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int CELL_W     = 2 * BYTE_W;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  // cells moved by a scroll, and the end of the line it clears
  localparam int COPY_LEN   = (ROWS - 2) * COLUMNS;
  localparam int CLEAR_END  = (ROWS - 1) * COLUMNS;

  localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic bs_write;
    logic init_wr;
    logic copy_step;
    logic clear_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bs_go;
    logic scroll_go;
    logic init_last;
    logic copy_last;
    logic clear_last;
  } sts_t;

endpackage

// File: hdl/tctw_if.sv
// ----------------------------------------------------------------------------
// tctw_if: channel interfaces of the text-cell terminal writer
// Input item, result item and attribute write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface tctw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [tctw_pkg::BYTE_W-1:0]  char_byte;
  logic [tctw_pkg::IDX_W-1:0]   cell_index;

  modport source (output valid, op, char_byte, cell_index, input ready);
  modport sink   (input valid, op, char_byte, cell_index, output ready);
endinterface

interface tctw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tctw_pkg::IDX_W-1:0]   cursor_position;
  logic [tctw_pkg::BYTE_W-1:0]  cell_char;
  logic [tctw_pkg::BYTE_W-1:0]  cell_attr;

  modport source (output valid, cursor_position, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_attr, output ready);
endinterface

interface tctw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tctw_pkg::BYTE_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/text_cell_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_cell_terminal_writer: text-cell terminal with cursor and screen store
// Puts characters into an 80x25 cell store with newline, backspace, wrap and
// scroll; reads back single cells; reports the linear cursor position.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 2000-cell store to character 0 and
// attribute 0x07, one cell a cycle, and takes no item until the sweep ends;
// attribute writes are taken at any time. An item passes from acceptance to
// a loaded result through accept, execute and result load; a backspace that
// clears a cell adds a write step after execute, since the single store write
// port needs a read and then a write of that cell. A put that reaches the
// bottom row adds a scroll that copies (ROWS-2)*COLUMNS cells up a row and
// then clears COLUMNS cells, bound by the one read and one write port of the
// store. The next item is accepted while the previous result still waits in
// the output register.
module text_cell_terminal_writer (
  input  logic       clk,
  input  logic       rst_n,
  tctw_in_if.sink    in_ch,
  tctw_out_if.source out_ch,
  tctw_cfg_if.sink   cfg_ch
);

  tctw_pkg::cmd_t cmd;
  tctw_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tctw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tctw_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_ch.valid),
    .cfg_data            (cfg_ch.data),
    .in_op               (in_ch.op),
    .in_char_byte        (in_ch.char_byte),
    .in_cell_index       (in_ch.cell_index),
    .out_cursor_position (out_ch.cursor_position),
    .out_cell_char       (out_ch.cell_char),
    .out_cell_attr       (out_ch.cell_attr)
  );

  // no transaction accepted while the store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.init_wr || cmd.copy_step || cmd.clear_wr) |-> !in_ch.ready)
    else $error("input accepted during store sweep");

  // an accepted item executes on the next cycle
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> cmd.exec)
    else $error("accepted item did not execute");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten");

  // a scroll only follows a put that reached the bottom row
  a_scroll_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.copy_step && !$past(cmd.copy_step)) |-> $past(cmd.exec && sts.scroll_go))
    else $error("scroll started without a put");

endmodule

// File: hdl/tctw_ram.sv
// ----------------------------------------------------------------------------
// tctw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/tctw_ctrl.sv
// ----------------------------------------------------------------------------
// tctw_ctrl: sequencing controller
// Runs the clearing pass, item execution, backspace read-modify-write,
// scroll copy/clear sweeps and the output handshake.
// ----------------------------------------------------------------------------
module tctw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  tctw_pkg::sts_t sts,
  output tctw_pkg::cmd_t cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_BSWR  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.bs_go)          state_nxt = S_BSWR;
        else if (sts.scroll_go) state_nxt = S_COPY;
        else                    state_nxt = S_FIN;
      end
      S_BSWR: begin
        cmd.bs_write = 1'b1;
        state_nxt    = S_FIN;
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        // result register must be empty or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/tctw_dp.sv
// ----------------------------------------------------------------------------
// tctw_dp: terminal datapath
// Cursor, attribute register, item and result registers, sweep counter and
// the screen store with its port muxing.
// ----------------------------------------------------------------------------
module tctw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tctw_pkg::cmd_t                cmd,
  output tctw_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [tctw_pkg::BYTE_W-1:0]   cfg_data,
  input  logic                          in_op,
  input  logic [tctw_pkg::BYTE_W-1:0]   in_char_byte,
  input  logic [tctw_pkg::IDX_W-1:0]    in_cell_index,
  output logic [tctw_pkg::IDX_W-1:0]    out_cursor_position,
  output logic [tctw_pkg::BYTE_W-1:0]   out_cell_char,
  output logic [tctw_pkg::BYTE_W-1:0]   out_cell_attr
);

  localparam int AW = tctw_pkg::ADDR_W;
  localparam int BW = tctw_pkg::BYTE_W;
  localparam logic [AW-1:0] COL_MUL    = AW'(tctw_pkg::COLUMNS);
  localparam logic [AW-1:0] INIT_LAST  = AW'(tctw_pkg::CELL_COUNT - 1);
  localparam logic [AW-1:0] COPY_LEN   = AW'(tctw_pkg::COPY_LEN);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(tctw_pkg::CLEAR_END - 1);
  localparam logic [tctw_pkg::IDX_W-1:0] IDX_LIMIT = tctw_pkg::IDX_W'(tctw_pkg::CELL_COUNT);
  localparam logic [tctw_pkg::COL_W-1:0] COL_LAST  = tctw_pkg::COL_W'(tctw_pkg::COLUMNS - 1);
  localparam logic [tctw_pkg::ROW_W-1:0] ROW_LAST  = tctw_pkg::ROW_W'(tctw_pkg::ROWS - 1);
  localparam logic [tctw_pkg::ROW_W-1:0] ROW_SCRL  = tctw_pkg::ROW_W'(tctw_pkg::ROWS - 2);

  logic                        op_r;
  logic [BW-1:0]               ch_r;
  logic [tctw_pkg::IDX_W-1:0]  idx_r;
  logic [tctw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tctw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [BW-1:0]               attr_r;
  logic [AW-1:0]               sweep_r, sweep_nxt;
  logic [AW-1:0]               bs_addr_r;
  logic [tctw_pkg::IDX_W-1:0]  pos_r;
  logic [BW-1:0]               rd_char_r, rd_attr_r;

  logic [AW-1:0]               cur_addr;
  logic [tctw_pkg::COL_W-1:0]  col_step;
  logic [tctw_pkg::ROW_W-1:0]  row_step;
  logic                        wr_char, bs_any, is_put, rd_ok;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  tctw_pkg::cell_t             ram_wdata, ram_rdata;

  assign cur_addr = AW'(row_r) * COL_MUL + AW'(col_r);
  assign is_put   = (op_r == tctw_pkg::OP_PUT);
  assign rd_ok    = (idx_r < IDX_LIMIT);

  // cursor motion for a put
  always_comb begin
    col_step = col_r;
    row_step = row_r;
    wr_char  = 1'b0;
    bs_any   = 1'b0;
    if (ch_r == tctw_pkg::CH_NEWLINE) begin
      col_step = '0;
      row_step = row_r + 1'b1;
    end else if (ch_r == tctw_pkg::CH_BACKSPACE) begin
      if (col_r != '0) begin
        col_step = col_r - 1'b1;
        bs_any   = 1'b1;
      end
    end else begin
      wr_char = 1'b1;
      if (col_r == COL_LAST) begin
        col_step = '0;
        row_step = row_r + 1'b1;
      end else begin
        col_step = col_r + 1'b1;
      end
    end
  end

  assign sts.bs_go      = is_put && bs_any;
  assign sts.scroll_go  = is_put && (row_step == ROW_LAST);
  assign sts.init_last  = (sweep_r == INIT_LAST);
  assign sts.copy_last  = (sweep_r == COPY_LEN);
  assign sts.clear_last = (sweep_r == CLEAR_LAST);

  // store port selection, one command active at a time
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = {tctw_pkg::ATTR_RESET, BW'(0)};
    ram_re    = 1'b0;
    ram_raddr = sweep_r + COL_MUL;
    if (cmd.init_wr) begin
      ram_we = 1'b1;
    end else if (cmd.exec) begin
      if (!is_put) begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
      end else if (bs_any) begin
        ram_re    = 1'b1;
        ram_raddr = cur_addr - 1'b1;
      end else if (wr_char) begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {attr_r, ch_r};
      end
    end else if (cmd.bs_write) begin
      ram_we    = 1'b1;
      ram_waddr = bs_addr_r;
      ram_wdata = {ram_rdata[2*BW-1:BW], BW'(0)};
    end else if (cmd.copy_step) begin
      // read one row ahead, write back the cell fetched last cycle
      ram_re    = !sts.copy_last;
      ram_we    = (sweep_r != '0);
      ram_waddr = sweep_r - 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {attr_r, BW'(0)};
    end
  end

  always_comb begin
    sweep_nxt = sweep_r;
    if (cmd.init_wr)        sweep_nxt = sts.init_last  ? '0       : sweep_r + 1'b1;
    else if (cmd.copy_step) sweep_nxt = sts.copy_last  ? COPY_LEN : sweep_r + 1'b1;
    else if (cmd.clear_wr)  sweep_nxt = sts.clear_last ? '0       : sweep_r + 1'b1;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.exec && is_put) begin
      col_nxt = col_step;
      row_nxt = sts.scroll_go ? ROW_SCRL : row_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      attr_r  <= tctw_pkg::ATTR_RESET;
      sweep_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sweep_r <= sweep_nxt;
      if (cfg_we) attr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= in_op;
      ch_r  <= in_char_byte;
      idx_r <= in_cell_index;
    end
    if (cmd.exec) begin
      bs_addr_r <= cur_addr - 1'b1;
    end
    if (cmd.load_out) begin
      pos_r <= tctw_pkg::IDX_W'(cur_addr);
      if (!is_put && rd_ok) begin
        rd_char_r <= ram_rdata[BW-1:0];
        rd_attr_r <= ram_rdata[2*BW-1:BW];
      end else begin
        rd_char_r <= '0;
        rd_attr_r <= '0;
      end
    end
  end

  tctw_ram #(
    .WIDTH (tctw_pkg::CELL_W),
    .DEPTH (tctw_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_cursor_position = pos_r;
  assign out_cell_char       = rd_char_r;
  assign out_cell_attr       = rd_attr_r;

endmodule

// File: verif/text_cell_terminal_writer_tb.sv
// ----------------------------------------------------------------------------
// text_cell_terminal_writer_tb: self-checking bench for the text-cell terminal
// Drives put and read items, mirrors the 80x25 screen store and cursor, and
// compares every cursor report and cell readback against the mirror while
// both channels stall at random and the attribute register changes.
// ----------------------------------------------------------------------------
module text_cell_terminal_writer_tb;
  import tctw_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 195;
  localparam int SHOW_MAX    = 10;

  typedef struct {
    logic              op;
    logic [BYTE_W-1:0] char_byte;
    logic [IDX_W-1:0]  cell_index;
  } term_item_t;

  typedef struct {
    logic [IDX_W-1:0]  cursor_position;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
  } cell_report_t;

  // Mirror of the screen store and cursor; predicts one report per item.
  class screen_mirror;
    cell_t             cells [CELL_COUNT];
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] attr;
    cell_report_t      awaited_reports [$];
    int                mismatches;
    int                puts;
    int                reads;
    int                scrolls;

    function new();
      foreach (cells[i]) cells[i] = {ATTR_RESET, 8'h00};
      col        = '0;
      row        = '0;
      attr       = ATTR_RESET;
      mismatches = 0;
      puts       = 0;
      reads      = 0;
      scrolls    = 0;
    endfunction

    function logic [IDX_W-1:0] cursor_cell();
      return IDX_W'(int'(row) * COLUMNS + int'(col));
    endfunction

    // rows 1..ROWS-2 move up, row ROWS-2 is cleared, bottom row untouched
    function void scroll_screen();
      for (int i = 0; i < COPY_LEN; i++) cells[i] = cells[i + COLUMNS];
      for (int i = COPY_LEN; i < CLEAR_END; i++) cells[i] = {attr, 8'h00};
      if (row >= 1) row = row - 1'b1;
      else begin
        row = '0;
        col = '0;
      end
      scrolls++;
    endfunction

    function void apply_put(logic [BYTE_W-1:0] ch);
      if (ch == CH_NEWLINE) begin
        col = '0;
        row = row + 1'b1;
      end else if (ch == CH_BACKSPACE) begin
        if (col > 0) begin
          col = col - 1'b1;
          cells[cursor_cell()][BYTE_W-1:0] = '0;
        end
      end else begin
        cells[cursor_cell()] = {attr, ch};
        col = col + 1'b1;
      end
      if (col >= COLUMNS) begin
        col = '0;
        row = row + 1'b1;
      end
      if (row >= ROWS - 1) scroll_screen();
    endfunction

    function void take_item(term_item_t it);
      cell_report_t rep;
      rep.cell_char = '0;
      rep.cell_attr = '0;
      if (it.op == OP_PUT) begin
        apply_put(it.char_byte);
        puts++;
      end else begin
        if (it.cell_index < CELL_COUNT) begin
          rep.cell_char = cells[it.cell_index][BYTE_W-1:0];
          rep.cell_attr = cells[it.cell_index][CELL_W-1:BYTE_W];
        end
        reads++;
      end
      rep.cursor_position = cursor_cell();
      awaited_reports.push_back(rep);
    endfunction

    function void match_report(cell_report_t got);
      cell_report_t want;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("ERROR: result with nothing pending: pos %0d char %02h attr %02h",
                   got.cursor_position, got.cell_char, got.cell_attr);
        return;
      end
      want = awaited_reports.pop_front();
      if (got.cursor_position !== want.cursor_position ||
          got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("ERROR: exp pos %0d char %02h attr %02h, got pos %0d char %02h attr %02h",
                   want.cursor_position, want.cell_char, want.cell_attr,
                   got.cursor_position, got.cell_char, got.cell_attr);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tctw_in_if  in_ch ();
  tctw_out_if out_ch ();
  tctw_cfg_if cfg_ch ();

  text_cell_terminal_writer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  screen_mirror screen = new();

  bit idling_on     = 1'b1;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  int attr_writes   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side: random stall bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_requests != holds_done) begin
      holds_done   <= hold_requests;
      hold_left    <= LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      hold_left    <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cell_report_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cursor_position = out_ch.cursor_position;
      got.cell_char       = out_ch.cell_char;
      got.cell_attr       = out_ch.cell_attr;
      screen.match_report(got);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("text_cell_terminal_writer_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic term_item_t put_char(logic [BYTE_W-1:0] ch);
    term_item_t it;
    it.op         = OP_PUT;
    it.char_byte  = ch;
    it.cell_index = IDX_W'($urandom_range(0, 2047));
    return it;
  endfunction

  function automatic term_item_t read_cell(int idx);
    term_item_t it;
    it.op         = OP_READ;
    it.char_byte  = BYTE_W'($urandom_range(0, 255));
    it.cell_index = IDX_W'(idx);
    return it;
  endfunction

  // mostly text with newlines and backspaces, reads near the cursor or anywhere
  function automatic term_item_t random_item();
    int pick;
    int near;
    pick = $urandom_range(0, 99);
    if (pick < 11) begin
      near = int'(screen.cursor_cell()) - int'($urandom_range(0, 160));
      return read_cell(near < 0 ? 0 : near);
    end
    if (pick < 22) return read_cell($urandom_range(0, 2047));
    if (pick < 30) return put_char(CH_NEWLINE);
    if (pick < 38) return put_char(CH_BACKSPACE);
    if (pick < 84) return put_char(BYTE_W'($urandom_range(8'h20, 8'h7E)));
    return put_char(BYTE_W'($urandom_range(0, 255)));
  endfunction

  task automatic send_item(term_item_t it);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= it.op;
    in_ch.char_byte  <= it.char_byte;
    in_ch.cell_index <= it.cell_index;
    do @(posedge clk); while (!in_ch.ready);
    screen.take_item(it);
  endtask

  task automatic wait_drained();
    while (screen.awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_text_attribute(logic [BYTE_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    screen.attr = value;
    attr_writes++;
  endtask

  task automatic run_text(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 40) hold_requests <= hold_requests + 1;
      send_item(random_item());
    end
    in_ch.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_PUT;
    in_ch.char_byte  <= '0;
    in_ch.cell_index <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // directed part with the reset attribute
    send_item(read_cell(0));
    send_item(read_cell(CELL_COUNT - 1));     // bottom row, reset contents
    send_item(read_cell(CELL_COUNT));         // just past the store
    send_item(read_cell(2047));
    send_item(read_cell(CLEAR_END));
    send_item(put_char(CH_BACKSPACE));        // column zero: no change
    send_item(put_char(8'h00));
    send_item(put_char(8'hFF));
    send_item(put_char(8'h41));
    send_item(put_char(CH_BACKSPACE));        // char cleared, attr kept
    send_item(read_cell(2));
    send_item(read_cell(1));
    send_item(read_cell(0));
    send_item(put_char(CH_NEWLINE));
    send_item(put_char(8'h7F));
    send_item(put_char(8'h80));
    send_item(read_cell(COLUMNS));
    send_item(put_char(CH_BACKSPACE));
    send_item(put_char(CH_BACKSPACE));
    send_item(put_char(CH_BACKSPACE));
    send_item(read_cell(COLUMNS + 1));
    in_ch.valid <= 1'b0;
    wait_drained();

    set_text_attribute(8'hFF);
    run_text(PHASE_ITEMS, 1'b0);
    set_text_attribute(8'h00);
    run_text(PHASE_ITEMS, 1'b1);
    set_text_attribute(BYTE_W'($urandom_range(1, 254)));
    run_text(PHASE_ITEMS, 1'b0);

    // last stretch with both sides streaming
    set_text_attribute(BYTE_W'($urandom_range(0, 255)));
    idling_on = 1'b0;
    run_text(PHASE_ITEMS, 1'b0);

    repeat (30) @(posedge clk);
    if (screen.awaited_reports.size() != 0) begin
      $display("ERROR: %0d results never arrived", screen.awaited_reports.size());
      screen.mismatches += screen.awaited_reports.size();
    end

    $display("covered %0d puts and %0d reads, %0d scrolls, %0d attribute settings",
             screen.puts, screen.reads, screen.scrolls, attr_writes + 1);
    $display("mismatches: %0d", screen.mismatches);
    if (screen.mismatches == 0)
      $display("text_cell_terminal_writer_tb OK");
    else
      $display("text_cell_terminal_writer_tb NOT OK");
    $finish;
  end
endmodule

// File: sim.f
hdl/tctw_pkg.sv
hdl/tctw_if.sv
hdl/tctw_ram.sv
hdl/tctw_ctrl.sv
hdl/tctw_dp.sv
hdl/text_cell_terminal_writer.sv
verif/text_cell_terminal_writer_tb.sv
